>>> rtl/assert_macros.svh
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/cpt_pkg.sv
// shared types and constants for the closest-point-on-triangle block
package cpt_pkg;

    localparam int CW = 32;                 // coordinate width
    localparam int EW = CW + 1;             // edge / offset vector width
    localparam int DW = 68;                 // dot product width
    localparam int HW = DW / 2;             // half of a dot product for partial products
    localparam int PW = 140;                // cross-term products and ratio operands
    localparam int WF = 16;                 // weight fraction bits
    localparam int WW = WF + 1;             // weight width
    localparam logic [WW-1:0] WEIGHT_ONE = WW'(1) << WF;
    localparam int DIV_STEPS = WF;
    localparam int DIV_LAT = DIV_STEPS + 3; // setup, range check, steps, rounding
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        RGN_A  = 3'd0,
        RGN_B  = 3'd1,
        RGN_AB = 3'd2,
        RGN_C  = 3'd3,
        RGN_AC = 3'd4,
        RGN_BC = 3'd5,
        RGN_IN = 3'd6
    } region_t;

    // one classified request handed from front to back
    typedef struct packed {
        logic [2:0][CW-1:0] base;
        logic [2:0][EW-1:0] e1;
        logic [2:0][EW-1:0] e2;
        region_t            region;
        logic               degen;
        logic [PW-1:0]      num1;
        logic [PW-1:0]      num2;
        logic [PW-1:0]      den;
    } job_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> rtl/cpt_front.sv
// front pipeline: dot products, cross terms and region classification
module cpt_front
    import cpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0][CW-1:0] p,
    input  logic [2:0][CW-1:0] a,
    input  logic [2:0][CW-1:0] b,
    input  logic [2:0][CW-1:0] c,
    input  q_stat_t            q_stat,
    output logic               job_valid,
    output job_t               job
);

    localparam int NST = 6;
    // operand pairs of the cross terms d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PY [6] = '{3, 1, 1, 5, 5, 3};

    typedef struct packed {
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [2:0][CW-1:0] c;
        logic [2:0][EW-1:0] ab;
        logic [2:0][EW-1:0] ac;
        logic [2:0][EW-1:0] bc;
    } geo_t;

    logic [NST-1:0] vld_reg;
    logic           adv;

    geo_t               g_next;
    geo_t               g_reg [NST];
    logic [2:0][EW-1:0] ap_next, bp_next, cp_next;
    logic [2:0][EW-1:0] ap_reg, bp_reg, cp_reg;

    logic signed [2*EW-1:0] m_next [6][3];
    logic signed [2*EW-1:0] m_reg  [6][3];

    logic signed [DW-1:0] d_next [6];
    logic signed [DW-1:0] d_reg  [6];

    logic        [2*HW-1:0] ll_next [6];
    logic signed [2*HW:0]   lh_next [6];
    logic signed [2*HW:0]   hl_next [6];
    logic signed [2*HW-1:0] hh_next [6];
    logic        [2*HW-1:0] ll_reg  [6];
    logic signed [2*HW:0]   lh_reg  [6];
    logic signed [2*HW:0]   hl_reg  [6];
    logic signed [2*HW-1:0] hh_reg  [6];
    logic signed [DW-1:0]   d4_reg  [6];

    logic signed [PW-1:0] t_hh [6];
    logic signed [PW-1:0] t_mid [6];
    logic signed [PW-1:0] t_ll [6];
    logic signed [PW-1:0] p_next [6];
    logic signed [PW-1:0] p_reg  [6];
    logic signed [DW-1:0] d5_reg [6];

    logic signed [PW-1:0] de_next [6];
    logic signed [PW-1:0] de_reg  [6];
    logic signed [PW-1:0] va_next, vb_next, vc_next;
    logic signed [PW-1:0] d43_next, d56_next, d13_next, d26_next;
    logic signed [PW-1:0] va_reg, vb_reg, vc_reg;
    logic signed [PW-1:0] d43_reg, d56_reg, d13_reg, d26_reg;

    logic signed [PW-1:0] den5, den6, den_sel;
    logic                 interp;

    function automatic logic le0(input logic signed [PW-1:0] x);
        return x[PW-1] || (x == '0);
    endfunction

    function automatic logic ge0(input logic signed [PW-1:0] x);
        return !x[PW-1];
    endfunction

    // pipeline moves whenever the queue can take the oldest request
    assign adv       = !vld_reg[NST-1] || !q_stat.full;
    assign in_ready  = adv;
    assign job_valid = vld_reg[NST-1] && !q_stat.full;

    // stage 1: edge and offset vectors
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            g_next.a[k]  = a[k];
            g_next.b[k]  = b[k];
            g_next.c[k]  = c[k];
            g_next.ab[k] = {b[k][CW-1], b[k]} - {a[k][CW-1], a[k]};
            g_next.ac[k] = {c[k][CW-1], c[k]} - {a[k][CW-1], a[k]};
            g_next.bc[k] = {c[k][CW-1], c[k]} - {b[k][CW-1], b[k]};
            ap_next[k]   = {p[k][CW-1], p[k]} - {a[k][CW-1], a[k]};
            bp_next[k]   = {p[k][CW-1], p[k]} - {b[k][CW-1], b[k]};
            cp_next[k]   = {p[k][CW-1], p[k]} - {c[k][CW-1], c[k]};
        end
    end

    // stage 2: per-axis products of the six dot products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m_next[0][k] = $signed(g_reg[0].ab[k]) * $signed(ap_reg[k]);
            m_next[1][k] = $signed(g_reg[0].ac[k]) * $signed(ap_reg[k]);
            m_next[2][k] = $signed(g_reg[0].ab[k]) * $signed(bp_reg[k]);
            m_next[3][k] = $signed(g_reg[0].ac[k]) * $signed(bp_reg[k]);
            m_next[4][k] = $signed(g_reg[0].ab[k]) * $signed(cp_reg[k]);
            m_next[5][k] = $signed(g_reg[0].ac[k]) * $signed(cp_reg[k]);
        end
    end

    // stage 3: dot products d1..d6
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            d_next[j] = DW'(m_reg[j][0]) + DW'(m_reg[j][1]) + DW'(m_reg[j][2]);
        end
    end

    // stage 4: partial products of the cross terms
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ll_next[i] = d_reg[PX[i]][HW-1:0] * d_reg[PY[i]][HW-1:0];
            lh_next[i] = $signed({1'b0, d_reg[PX[i]][HW-1:0]}) * $signed(d_reg[PY[i]][DW-1:HW]);
            hl_next[i] = $signed(d_reg[PX[i]][DW-1:HW]) * $signed({1'b0, d_reg[PY[i]][HW-1:0]});
            hh_next[i] = $signed(d_reg[PX[i]][DW-1:HW]) * $signed(d_reg[PY[i]][DW-1:HW]);
        end
    end

    // stage 5: combine partial products
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            t_hh[i]   = PW'(hh_reg[i]);
            t_mid[i]  = PW'(lh_reg[i]) + PW'(hl_reg[i]);
            t_ll[i]   = PW'($signed({1'b0, ll_reg[i]}));
            p_next[i] = (t_hh[i] <<< (2 * HW)) + (t_mid[i] <<< HW) + t_ll[i];
        end
    end

    // stage 6: barycentric cross terms and dot differences
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            de_next[j] = PW'(d5_reg[j]);
        end
        vc_next  = p_reg[0] - p_reg[1];
        vb_next  = p_reg[2] - p_reg[3];
        va_next  = p_reg[4] - p_reg[5];
        d43_next = de_next[3] - de_next[2];
        d56_next = de_next[4] - de_next[5];
        d13_next = de_next[0] - de_next[2];
        d26_next = de_next[1] - de_next[5];
    end

    // classification into the seven regions, first match wins
    always_comb
    begin
        den5    = d43_reg + d56_reg;
        den6    = va_reg + vb_reg + vc_reg;
        den_sel = den6;
        interp  = 1'b0;
        job.base   = g_reg[NST-1].a;
        job.e1     = g_reg[NST-1].ab;
        job.e2     = g_reg[NST-1].ac;
        job.region = RGN_A;
        job.degen  = 1'b0;
        job.num1   = '0;
        job.num2   = '0;
        job.den    = den6;
        priority if (le0(de_reg[0]) && le0(de_reg[1]))
        begin
            job.region = RGN_A;
        end
        else if (ge0(de_reg[2]) && le0(d43_reg))
        begin
            job.region = RGN_B;
            job.base   = g_reg[NST-1].b;
        end
        else if (le0(vc_reg) && ge0(de_reg[0]) && le0(de_reg[2]))
        begin
            job.region = RGN_AB;
            job.num1   = de_reg[0];
            den_sel    = d13_reg;
            interp     = 1'b1;
        end
        else if (ge0(de_reg[5]) && le0(d56_reg))
        begin
            job.region = RGN_C;
            job.base   = g_reg[NST-1].c;
        end
        else if (le0(vb_reg) && ge0(de_reg[1]) && le0(de_reg[5]))
        begin
            job.region = RGN_AC;
            job.e1     = g_reg[NST-1].ac;
            job.num1   = de_reg[1];
            den_sel    = d26_reg;
            interp     = 1'b1;
        end
        else if (le0(va_reg) && ge0(d43_reg) && ge0(d56_reg))
        begin
            job.region = RGN_BC;
            job.base   = g_reg[NST-1].b;
            job.e1     = g_reg[NST-1].bc;
            job.num1   = d43_reg;
            den_sel    = den5;
            interp     = 1'b1;
        end
        else
        begin
            job.region = RGN_IN;
            job.num1   = vb_reg;
            job.num2   = vc_reg;
            interp     = 1'b1;
        end
        job.den = den_sel;
        // zero divisor falls back to vertex a
        if (interp && (den_sel == '0))
        begin
            job.region = RGN_A;
            job.base   = g_reg[NST-1].a;
            job.degen  = 1'b1;
            job.num1   = '0;
            job.num2   = '0;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_reg[0] <= g_next;
            for (int s = 1; s < NST; s++)
            begin
                g_reg[s] <= g_reg[s-1];
            end
            ap_reg <= ap_next;
            bp_reg <= bp_next;
            cp_reg <= cp_next;
            m_reg  <= m_next;
            d_reg  <= d_next;
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
            d4_reg <= d_reg;
            p_reg  <= p_next;
            d5_reg <= d4_reg;
            de_reg <= de_next;
            va_reg  <= va_next;
            vb_reg  <= vb_next;
            vc_reg  <= vc_next;
            d43_reg <= d43_next;
            d56_reg <= d56_next;
            d13_reg <= d13_next;
            d26_reg <= d26_next;
        end
    end

endmodule

>>> rtl/cpt_fifo.sv
// short request queue between front and back
module cpt_fifo
    import cpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    wdata,
    input  logic    pop,
    output job_t    rdata,
    output q_stat_t stat
);

    job_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   cnt_reg;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/cpt_div.sv
// pipelined rounded ratio: round(num * 2^16 / den) limited to [0, 1.0]
module cpt_div
    import cpt_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [PW-1:0] num,
    input  logic [PW-1:0] den,
    output logic [WW-1:0] quot
);

    logic                 fix0_next, fix0_reg;
    logic [PW-1:0]        nm0_next, dm0_next, nm0_reg, dm0_reg;

    logic [PW-1:0]        r_next  [DIV_STEPS+1];
    logic [PW-1:0]        r_reg   [DIV_STEPS+1];
    logic [PW-1:0]        dm_next [DIV_STEPS+1];
    logic [PW-1:0]        dm_reg  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_next  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS+1];
    logic                 fix_next [DIV_STEPS+1];
    logic                 fix_reg  [DIV_STEPS+1];
    logic                 one_next [DIV_STEPS+1];
    logic                 one_reg  [DIV_STEPS+1];

    logic [PW:0]          r2;
    logic                 ge;
    logic [PW:0]          rf2;
    logic                 gef;
    logic [WW-1:0]        quot_next, quot_reg;

    assign quot = quot_reg;

    // setup: zero and sign cases, magnitudes
    always_comb
    begin
        fix0_next = (num == '0) || (den == '0) || (num[PW-1] != den[PW-1]);
        nm0_next  = num[PW-1] ? (~num + PW'(1)) : num;
        dm0_next  = den[PW-1] ? (~den + PW'(1)) : den;
    end

    // range check, then one quotient bit per stage
    always_comb
    begin
        fix_next[0] = fix0_reg || (nm0_reg >= dm0_reg);
        one_next[0] = !fix0_reg;
        r_next[0]   = nm0_reg;
        dm_next[0]  = dm0_reg;
        q_next[0]   = '0;
        r2 = '0;
        ge = 1'b0;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            r2          = {r_reg[k-1], 1'b0};
            ge          = (r2 >= {1'b0, dm_reg[k-1]});
            r_next[k]   = ge ? PW'(r2 - {1'b0, dm_reg[k-1]}) : r2[PW-1:0];
            dm_next[k]  = dm_reg[k-1];
            q_next[k]   = {q_reg[k-1][DIV_STEPS-2:0], ge};
            fix_next[k] = fix_reg[k-1];
            one_next[k] = one_reg[k-1];
        end
    end

    // round half up and select the fixed answers
    always_comb
    begin
        rf2 = {r_reg[DIV_STEPS], 1'b0};
        gef = (rf2 >= {1'b0, dm_reg[DIV_STEPS]});
        if (fix_reg[DIV_STEPS])
        begin
            quot_next = one_reg[DIV_STEPS] ? WEIGHT_ONE : '0;
        end
        else
        begin
            quot_next = {1'b0, q_reg[DIV_STEPS]} + WW'(gef);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fix0_reg <= fix0_next;
            nm0_reg  <= nm0_next;
            dm0_reg  <= dm0_next;
            r_reg    <= r_next;
            dm_reg   <= dm_next;
            q_reg    <= q_next;
            fix_reg  <= fix_next;
            one_reg  <= one_next;
            quot_reg <= quot_next;
        end
    end

endmodule

>>> rtl/cpt_back.sv
// back pipeline: ratios, weights, interpolation and output register
module cpt_back
    import cpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  job_t               head,
    input  q_stat_t            q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0][CW-1:0] near,
    output logic [WW-1:0]      wa,
    output logic [WW-1:0]      wb,
    output logic [WW-1:0]      wc,
    output region_t            region,
    output logic               degen
);

    localparam int MW = WW + EW;   // weight times edge
    localparam int SW = MW + 1;    // sum of two such products
    localparam int NW = CW + 4;    // base plus rounded offset

    typedef struct packed {
        logic [2:0][CW-1:0] base;
        logic [2:0][EW-1:0] e1;
        logic [2:0][EW-1:0] e2;
        region_t            region;
        logic               degen;
    } side_t;

    logic               adv;
    logic [WW-1:0]      q1, q2;
    logic [DIV_LAT-1:0] vld_reg;
    side_t              sd_next;
    side_t              sd_reg [DIV_LAT];
    side_t              sl;

    logic [WW-1:0]           wa_next, wb_next, wc_next;
    logic [WW:0]             wsum;
    logic signed [MW-1:0]    pr1_next [3];
    logic signed [MW-1:0]    pr2_next [3];
    logic signed [MW-1:0]    pr1_reg  [3];
    logic signed [MW-1:0]    pr2_reg  [3];
    logic                    i_vld_reg;
    logic [2:0][CW-1:0]      i_base_reg;
    region_t                 i_region_reg;
    logic                    i_degen_reg;
    logic [WW-1:0]           i_wa_reg, i_wb_reg, i_wc_reg;

    logic signed [SW-1:0]    acc [3];
    logic signed [SW-1:0]    rnd [3];
    logic signed [NW-1:0]    sum [3];
    logic [2:0][CW-1:0]      near_next;

    logic                    out_valid_reg;
    logic [2:0][CW-1:0]      near_reg;
    logic [WW-1:0]           wa_reg, wb_reg, wc_reg;
    region_t                 region_reg;
    logic                    degen_reg;

    // the whole back pipeline holds while a finished result waits
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !q_stat.empty;

    cpt_div u_div1 (
        .clk  (clk),
        .en   (adv),
        .num  (head.num1),
        .den  (head.den),
        .quot (q1)
    );

    cpt_div u_div2 (
        .clk  (clk),
        .en   (adv),
        .num  (head.num2),
        .den  (head.den),
        .quot (q2)
    );

    // side data riding along with the dividers
    always_comb
    begin
        sd_next.base   = head.base;
        sd_next.e1     = head.e1;
        sd_next.e2     = head.e2;
        sd_next.region = head.region;
        sd_next.degen  = head.degen;
    end

    assign sl = sd_reg[DIV_LAT-1];

    // weights by region, and weighted edge products
    always_comb
    begin
        wsum    = {1'b0, q1} + {1'b0, q2};
        wa_next = '0;
        wb_next = '0;
        wc_next = '0;
        unique case (sl.region)
            RGN_A:  wa_next = WEIGHT_ONE;
            RGN_B:  wb_next = WEIGHT_ONE;
            RGN_C:  wc_next = WEIGHT_ONE;
            RGN_AB:
            begin
                wa_next = WEIGHT_ONE - q1;
                wb_next = q1;
            end
            RGN_AC:
            begin
                wa_next = WEIGHT_ONE - q1;
                wc_next = q1;
            end
            RGN_BC:
            begin
                wb_next = WEIGHT_ONE - q1;
                wc_next = q1;
            end
            RGN_IN:
            begin
                wb_next = q1;
                wc_next = q2;
                wa_next = (wsum >= {1'b0, WEIGHT_ONE}) ? '0 : WEIGHT_ONE - q1 - q2;
            end
            default:
            begin
                wa_next = '0;
            end
        endcase
        for (int k = 0; k < 3; k++)
        begin
            pr1_next[k] = MW'($signed({1'b0, q1}) * $signed(sl.e1[k]));
            pr2_next[k] = MW'($signed({1'b0, q2}) * $signed(sl.e2[k]));
        end
    end

    // round the offset, add the base and saturate
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = SW'(pr1_reg[k]) + SW'(pr2_reg[k]);
            rnd[k] = (acc[k] + SW'(1 << (WF - 1))) >>> WF;
            sum[k] = NW'($signed(i_base_reg[k]) + rnd[k]);
            if (sum[k][NW-1:CW-1] == '0 || sum[k][NW-1:CW-1] == '1)
            begin
                near_next[k] = sum[k][CW-1:0];
            end
            else if (sum[k][NW-1])
            begin
                near_next[k] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                near_next[k] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            i_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[DIV_LAT-2:0], !q_stat.empty};
            i_vld_reg     <= vld_reg[DIV_LAT-1];
            out_valid_reg <= i_vld_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= sd_next;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                sd_reg[s] <= sd_reg[s-1];
            end
            pr1_reg      <= pr1_next;
            pr2_reg      <= pr2_next;
            i_base_reg   <= sl.base;
            i_region_reg <= sl.region;
            i_degen_reg  <= sl.degen;
            i_wa_reg     <= wa_next;
            i_wb_reg     <= wb_next;
            i_wc_reg     <= wc_next;
            near_reg     <= near_next;
            wa_reg       <= i_wa_reg;
            wb_reg       <= i_wb_reg;
            wc_reg       <= i_wc_reg;
            region_reg   <= i_region_reg;
            degen_reg    <= i_degen_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign near      = near_reg;
    assign wa        = wa_reg;
    assign wb        = wb_reg;
    assign wc        = wc_reg;
    assign region    = region_reg;
    assign degen     = degen_reg;

endmodule

>>> rtl/closest_point_on_triangle.sv
// top level: closest point on a triangle with barycentric weights
// throughput: one request per cycle while the output is not held, set by the pipelined 16-step ratio dividers
// a 4-entry queue lets the front keep taking requests while the output is held, until the queue and the front fill
// reset: asynchronous active-low rst_n clears all valid bits and the queue
`include "assert_macros.svh"
module closest_point_on_triangle
    import cpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] query_x,
    input  logic signed [CW-1:0] query_y,
    input  logic signed [CW-1:0] query_z,
    input  logic signed [CW-1:0] vert_a_x,
    input  logic signed [CW-1:0] vert_a_y,
    input  logic signed [CW-1:0] vert_a_z,
    input  logic signed [CW-1:0] vert_b_x,
    input  logic signed [CW-1:0] vert_b_y,
    input  logic signed [CW-1:0] vert_b_z,
    input  logic signed [CW-1:0] vert_c_x,
    input  logic signed [CW-1:0] vert_c_y,
    input  logic signed [CW-1:0] vert_c_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] near_x,
    output logic signed [CW-1:0] near_y,
    output logic signed [CW-1:0] near_z,
    output logic [WW-1:0]        weight_a,
    output logic [WW-1:0]        weight_b,
    output logic [WW-1:0]        weight_c,
    output logic [2:0]           region,
    output logic                 degenerate
);

    logic [2:0][CW-1:0] p, a, b, c;
    logic [2:0][CW-1:0] near;
    q_stat_t            q_stat;
    logic               q_push, q_pop;
    job_t               q_wdata, q_head;
    region_t            region_o;

    assign p = {query_z, query_y, query_x};
    assign a = {vert_a_z, vert_a_y, vert_a_x};
    assign b = {vert_b_z, vert_b_y, vert_b_x};
    assign c = {vert_c_z, vert_c_y, vert_c_x};

    cpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .p         (p),
        .a         (a),
        .b         (b),
        .c         (c),
        .q_stat    (q_stat),
        .job_valid (q_push),
        .job       (q_wdata)
    );

    cpt_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_head),
        .stat  (q_stat)
    );

    cpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .near      (near),
        .wa        (weight_a),
        .wb        (weight_b),
        .wc        (weight_c),
        .region    (region_o),
        .degen     (degenerate)
    );

    assign near_x = near[0];
    assign near_y = near[1];
    assign near_z = near[2];
    assign region = region_o;

    // weights sum to one everywhere but the interior
    `ASSERT_IMPLIES(a_weight_sum, clk, rst_n, out_valid && (region_o != RGN_IN), ({2'b00, weight_a} + {2'b00, weight_b} + {2'b00, weight_c}) == {2'b00, WEIGHT_ONE})
    // a zero divisor always reports vertex a alone
    `ASSERT_IMPLIES(a_degen_vertex, clk, rst_n, out_valid && degenerate, (region_o == RGN_A) && (weight_a == WEIGHT_ONE))
    // front takes requests whenever the queue has room
    `ASSERT_IMPLIES(a_front_free, clk, rst_n, !q_stat.full, in_ready)
    // nothing is popped from an empty queue
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, q_pop, !q_stat.empty)

endmodule

>>> test/tb.sv
// testbench for closest_point_on_triangle: directed table, then random requests vs predictor
module tb;
    import cpt_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        logic signed [CW-1:0] nz;
        logic [WW-1:0]        wa;
        logic [WW-1:0]        wb;
        logic [WW-1:0]        wc;
        region_t              rgn;
        logic                 degen;
    } near_res_t;

    typedef struct {
        logic signed [CW-1:0] crd [12];
        bit                   typed;
        near_res_t            res;
    } tri_row_t;

    localparam logic signed [CW-1:0] U = 32'sd65536;
    localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
    localparam logic signed [CW-1:0] CMIN = 32'sh80000000;
    localparam int LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready, out_valid;
    logic signed [CW-1:0] crd [12];
    logic signed [CW-1:0] near_x, near_y, near_z;
    logic [WW-1:0] weight_a, weight_b, weight_c;
    logic [2:0] region;
    logic degenerate;

    near_res_t expected_q [$];
    tri_row_t  dir_rows [$];
    int errors = 0;
    int n_req = 0;
    int n_res = 0;
    int rgn_seen [8];
    int n_degen = 0;
    int cycles = 0;
    int stall_mode = 0;

    initial
    begin
        foreach (crd[i]) crd[i] = '0;
    end

    closest_point_on_triangle dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .query_x(crd[0]), .query_y(crd[1]), .query_z(crd[2]),
        .vert_a_x(crd[3]), .vert_a_y(crd[4]), .vert_a_z(crd[5]),
        .vert_b_x(crd[6]), .vert_b_y(crd[7]), .vert_b_z(crd[8]),
        .vert_c_x(crd[9]), .vert_c_y(crd[10]), .vert_c_z(crd[11]),
        .out_valid(out_valid), .out_ready(out_ready),
        .near_x(near_x), .near_y(near_y), .near_z(near_z),
        .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
        .region(region), .degenerate(degenerate)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int sgn(wide_t v);
        if (v < 0)
            return -1;
        return (v == 0) ? 0 : 1;
    endfunction

    // round(num * 2^16 / den), clamped to [0, 1.0]; opposite signs give 0
    function automatic logic [WW-1:0] weight_ratio(wide_t num, wide_t den);
        logic [255:0] n, d, q, r;
        if (sgn(num) == 0 || sgn(num) != sgn(den))
            return '0;
        n = (num < 0) ? -num : num;
        d = (num < 0) ? -den : den;
        if (n >= d)
            return WEIGHT_ONE;
        q = (n << WF) / d;
        r = (n << WF) - q * d;
        if ((r << 1) >= d)
            q = q + 1;
        return q[WW-1:0];
    endfunction

    function automatic wide_t dot(longint u [3], longint v [3]);
        return wide_t'(u[0]) * wide_t'(v[0]) + wide_t'(u[1]) * wide_t'(v[1])
             + wide_t'(u[2]) * wide_t'(v[2]);
    endfunction

    function automatic logic signed [CW-1:0] sat(longint v);
        if (v > 64'sd2147483647)
            return CMAX;
        if (v < -64'sd2147483648)
            return CMIN;
        return v[CW-1:0];
    endfunction

    // closest point, weights and region of one request
    function automatic near_res_t closest_point(logic signed [CW-1:0] c [12]);
        near_res_t r;
        longint p[3], a[3], b[3], cv[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        longint base[3], e1[3], e2[3], nr[3], acc;
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, den;
        logic [WW-1:0] w1, w2;
        bit interp;
        w1 = '0;
        w2 = '0;
        interp = 0;
        r.wa = '0;
        r.wb = '0;
        r.wc = '0;
        r.degen = 0;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = c[k];
            a[k] = c[3 + k];
            b[k] = c[6 + k];
            cv[k] = c[9 + k];
            ab[k] = b[k] - a[k];
            ac[k] = cv[k] - a[k];
            bc[k] = cv[k] - b[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - cv[k];
            base[k] = a[k];
            e1[k] = ab[k];
            e2[k] = ac[k];
            nr[k] = a[k];
        end
        d1 = dot(ab, ap);
        d2 = dot(ac, ap);
        d3 = dot(ab, bp);
        d4 = dot(ac, bp);
        d5 = dot(ab, cp);
        d6 = dot(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        // region tests in priority order
        if (d1 <= 0 && d2 <= 0)
        begin
            r.rgn = RGN_A;
            r.wa = WEIGHT_ONE;
        end
        else if (d3 >= 0 && d4 - d3 <= 0)
        begin
            r.rgn = RGN_B;
            r.wb = WEIGHT_ONE;
            nr = b;
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            r.rgn = RGN_AB;
            interp = 1;
            den = d1 - d3;
            if (den == 0)
                r.degen = 1;
            else
            begin
                w1 = weight_ratio(d1, den);
                r.wa = WEIGHT_ONE - w1;
                r.wb = w1;
            end
        end
        else if (d6 >= 0 && d5 - d6 <= 0)
        begin
            r.rgn = RGN_C;
            r.wc = WEIGHT_ONE;
            nr = cv;
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            r.rgn = RGN_AC;
            interp = 1;
            den = d2 - d6;
            if (den == 0)
                r.degen = 1;
            else
            begin
                w2 = weight_ratio(d2, den);
                r.wa = WEIGHT_ONE - w2;
                r.wc = w2;
            end
        end
        else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0)
        begin
            r.rgn = RGN_BC;
            interp = 1;
            den = (d4 - d3) + (d5 - d6);
            if (den == 0)
                r.degen = 1;
            else
            begin
                w1 = weight_ratio(d4 - d3, den);
                r.wb = WEIGHT_ONE - w1;
                r.wc = w1;
                base = b;
                e1 = bc;
            end
        end
        else
        begin
            r.rgn = RGN_IN;
            interp = 1;
            den = va + vb + vc;
            if (den == 0)
                r.degen = 1;
            else
            begin
                w1 = weight_ratio(vb, den);
                w2 = weight_ratio(vc, den);
                r.wb = w1;
                r.wc = w2;
                r.wa = (({1'b0, w1} + {1'b0, w2}) >= {1'b0, WEIGHT_ONE}) ? '0
                                                                           : WEIGHT_ONE - w1 - w2;
            end
        end
        // zero divisor falls back to vertex a
        if (r.degen)
        begin
            r.rgn = RGN_A;
            r.wa = WEIGHT_ONE;
            r.wb = '0;
            r.wc = '0;
            nr = a;
        end
        else if (interp)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc = longint'(w1) * e1[k] + longint'(w2) * e2[k];
                nr[k] = base[k] + ((acc + 64'sd32768) >>> WF);
            end
        end
        r.nx = sat(nr[0]);
        r.ny = sat(nr[1]);
        r.nz = sat(nr[2]);
        return r;
    endfunction

    task automatic add_row(input longint v [12], input bit typed, input near_res_t res);
        tri_row_t row;
        foreach (v[i]) row.crd[i] = v[i];
        row.typed = typed;
        row.res = res;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // present one request and hold it until accepted; gap chosen by caller
    task automatic send_request(input logic signed [CW-1:0] c [12], input bit typed,
                                input near_res_t res);
        in_valid <= 1'b1;
        foreach (c[i]) crd[i] <= c[i];
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.insert(expected_q.size(), typed ? res : closest_point(c));
        n_req++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
            2: return $signed($urandom_range(0, 64)) - 32;
            default: return ($urandom_range(0, 1)) ? CMAX - $urandom_range(0, 3)
                                                   : CMIN + $urandom_range(0, 3);
        endcase
    endfunction

    // random triangle/query with a mix of shapes
    function automatic void rand_request(output logic signed [CW-1:0] c [12]);
        int kind, shape;
        longint t;
        kind = $urandom_range(0, 9);
        kind = (kind < 3) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
        for (int i = 0; i < 12; i++)
            c[i] = rand_coord(kind);
        shape = $urandom_range(0, 7);
        case (shape)
            // repeated vertex
            0: for (int k = 0; k < 3; k++) c[6 + k] = c[3 + k];
            1: for (int k = 0; k < 3; k++) c[9 + k] = c[6 + $urandom_range(0, 1) * 0 + k];
            // collinear vertices: c = a + 2(b - a) along one line
            2: for (int k = 0; k < 3; k++)
               begin
                   t = longint'(c[3 + k]) + 2 * (longint'(c[6 + k]) - longint'(c[3 + k]));
                   c[9 + k] = sat(t);
               end
            // query on a vertex
            3: for (int k = 0; k < 3; k++) c[k] = c[3 + 3 * $urandom_range(0, 2) + k];
            default: ;
        endcase
    endfunction

    // receiver stall pattern
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= (cycles % 7) < 2;
            default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
        if (cycles % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            near_res_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected", $time);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                n_res++;
                rgn_seen[region]++;
                if (degenerate)
                    n_degen++;
                if ({near_x, near_y, near_z} !== {e.nx, e.ny, e.nz})
                begin
                    $display("%0t: near exp %0d %0d %0d got %0d %0d %0d", $time,
                             e.nx, e.ny, e.nz, near_x, near_y, near_z);
                    errors++;
                end
                if ({weight_a, weight_b, weight_c} !== {e.wa, e.wb, e.wc})
                begin
                    $display("%0t: weights exp %0d %0d %0d got %0d %0d %0d", $time,
                             e.wa, e.wb, e.wc, weight_a, weight_b, weight_c);
                    errors++;
                end
                if (region !== e.rgn)
                begin
                    $display("%0t: region exp %0d got %0d", $time, e.rgn, region);
                    errors++;
                end
                if (degenerate !== e.degen)
                begin
                    $display("%0t: degenerate exp %0b got %0b", $time, e.degen, degenerate);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        near_res_t none, ex;
        logic signed [CW-1:0] c [12];
        int burst;
        none = '{default: '0, rgn: RGN_A};
        // all zero: vertex a region
        ex = '{nx: 0, ny: 0, nz: 0, wa: WEIGHT_ONE, wb: 0, wc: 0, rgn: RGN_A, degen: 0};
        add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, ex);
        // query on a
        add_row('{0, 0, 0, 0, 0, 0, U, 0, 0, 0, U, 0}, 1, ex);
        // query on b
        ex = '{nx: U, ny: 0, nz: 0, wa: 0, wb: WEIGHT_ONE, wc: 0, rgn: RGN_B, degen: 0};
        add_row('{U, 0, 0, 0, 0, 0, U, 0, 0, 0, U, 0}, 1, ex);
        // query on c
        ex = '{nx: 0, ny: U, nz: 0, wa: 0, wb: 0, wc: WEIGHT_ONE, rgn: RGN_C, degen: 0};
        add_row('{0, U, 0, 0, 0, 0, U, 0, 0, 0, U, 0}, 1, ex);
        // a == b, query off the line: zero divisor on edge ab
        ex = '{nx: 0, ny: 0, nz: 0, wa: WEIGHT_ONE, wb: 0, wc: 0, rgn: RGN_A, degen: 1};
        add_row('{U / 2, U, 0, 0, 0, 0, 0, 0, 0, U, 0, 0}, 1, ex);
        // edges, interior, beyond each vertex
        add_row('{2 * U, -U, 0, 0, 0, 0, 4 * U, 0, 0, 0, 4 * U, 0}, 0, none);
        add_row('{-U, 2 * U, 3, 0, 0, 0, 4 * U, 0, 0, 0, 4 * U, 0}, 0, none);
        add_row('{3 * U, 3 * U, -U, 0, 0, 0, 4 * U, 0, 0, 0, 4 * U, 0}, 0, none);
        add_row('{U, U, 5 * U, 0, 0, 0, 4 * U, 0, 0, 0, 4 * U, 0}, 0, none);
        add_row('{-U, -U, 0, 0, 0, 0, 4 * U, 0, 0, 0, 4 * U, 0}, 0, none);
        add_row('{9 * U, -U, 0, 0, 0, 0, 4 * U, 0, 0, 0, 4 * U, 0}, 0, none);
        add_row('{-U, 9 * U, 0, 0, 0, 0, 4 * U, 0, 0, 0, 4 * U, 0}, 0, none);
        add_row('{7, 5, 3, 1, 0, 0, 11, 0, 0, 0, 13, 0}, 0, none);
        // collinear triangle, query beside it
        add_row('{U / 2, U, 0, 0, 0, 0, U, 0, 0, 2 * U, 0, 0}, 0, none);
        add_row('{3 * U, U, 0, 0, 0, 0, U, 0, 0, 2 * U, 0, 0}, 0, none);
        // coordinate extremes
        add_row('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN},
                0, none);
        add_row('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX},
                0, none);
        add_row('{0, 0, 0, CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0}, 0, none);
        add_row('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX},
                0, none);
        add_row('{-1, -1, -1, CMIN, 0, CMAX, CMAX, 0, CMIN, 0, CMAX, CMIN}, 0, none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].crd, dir_rows[i].typed, dir_rows[i].res);
            idle_gap($urandom_range(0, 2));
        end

        for (int i = 0; i < 600; )
        begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst; j++)
            begin
                rand_request(c);
                send_request(c, 0, none);
                i++;
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            // drain fully once, mid-run
            if (i >= 300 && i < 300 + burst)
            begin
                in_valid <= 1'b0;
                while (expected_q.size() != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("tb: %0d requests, %0d results, %0d with zero divisor", n_req, n_res,
                 n_degen);
        $display("tb: regions a %0d b %0d ab %0d c %0d ac %0d bc %0d inside %0d",
                 rgn_seen[0], rgn_seen[1], rgn_seen[2], rgn_seen[3], rgn_seen[4],
                 rgn_seen[5], rgn_seen[6]);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> closest_point_on_triangle.f
+incdir+rtl
rtl/cpt_pkg.sv
rtl/cpt_front.sv
rtl/cpt_fifo.sv
rtl/cpt_div.sv
rtl/cpt_back.sv
rtl/closest_point_on_triangle.sv
test/tb.sv
